// File: rtl/lrs_pkg.sv
package lrs_pkg;

    localparam int CFG_W = 32;

    // Configuration register indexes.
    localparam logic [2:0] REG_BACKOFF_MIN     = 3'd0;
    localparam logic [2:0] REG_BACKOFF_MAX     = 3'd1;
    localparam logic [2:0] REG_CONNECT_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_PROBE_INTERVAL  = 3'd3;
    localparam logic [2:0] REG_PORTAL_FALLBACK = 3'd4;

    localparam logic [CFG_W-1:0] BACKOFF_MIN_RST     = 32'd1000;
    localparam logic [CFG_W-1:0] BACKOFF_MAX_RST     = 32'd60000;
    localparam logic [CFG_W-1:0] CONNECT_TIMEOUT_RST = 32'd15000;
    localparam logic [CFG_W-1:0] PROBE_INTERVAL_RST  = 32'd30000;
    localparam logic [CFG_W-1:0] PORTAL_FALLBACK_RST = 32'd120000;

    // Event codes.
    localparam logic [1:0] FUNC_TICK          = 2'd0;
    localparam logic [1:0] FUNC_START         = 2'd1;
    localparam logic [1:0] FUNC_CREDS_SAVED   = 2'd2;
    localparam logic [1:0] FUNC_CREDS_CLEARED = 2'd3;

    // Link state codes as reported on the result.
    localparam logic [1:0] LINK_DOWN       = 2'd0;
    localparam logic [1:0] LINK_CONNECTING = 2'd1;
    localparam logic [1:0] LINK_UP         = 2'd2;

    typedef enum logic [2:0] {
        LS_DOWN       = 3'b001,
        LS_CONNECTING = 3'b010,
        LS_UP         = 3'b100
    } link_fsm_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic        link_up;
        logic        probe_ok;
        logic        creds_present;
    } in_item_t;

    typedef struct packed {
        logic [1:0] link_state;
        logic       issue_connect;
        logic       issue_disconnect;
        logic       ev_connected;
        logic       ev_lost;
        logic       ev_timeout;
        logic       probe_used;
        logic       portal_start;
        logic       portal_stop;
        logic       portal_active;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] backoff_min_ms;
        logic [CFG_W-1:0] backoff_max_ms;
        logic [CFG_W-1:0] connect_timeout_ms;
        logic [CFG_W-1:0] probe_interval_ms;
        logic [CFG_W-1:0] portal_fallback_ms;
    } cfg_regs_t;

endpackage

// File: rtl/lrs_cfg.sv
module lrs_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [lrs_pkg::CFG_W-1:0]  cfg_data,
    output lrs_pkg::cfg_regs_t         regs
);
    import lrs_pkg::*;

    cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.backoff_min_ms     <= BACKOFF_MIN_RST;
            regs_reg.backoff_max_ms     <= BACKOFF_MAX_RST;
            regs_reg.connect_timeout_ms <= CONNECT_TIMEOUT_RST;
            regs_reg.probe_interval_ms  <= PROBE_INTERVAL_RST;
            regs_reg.portal_fallback_ms <= PORTAL_FALLBACK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BACKOFF_MIN:     regs_reg.backoff_min_ms     <= cfg_data;
                REG_BACKOFF_MAX:     regs_reg.backoff_max_ms     <= cfg_data;
                REG_CONNECT_TIMEOUT: regs_reg.connect_timeout_ms <= cfg_data;
                REG_PROBE_INTERVAL:  regs_reg.probe_interval_ms  <= cfg_data;
                REG_PORTAL_FALLBACK: regs_reg.portal_fallback_ms <= cfg_data;
                default:             regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

// File: rtl/lrs_in_buf.sv
module lrs_in_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lrs_pkg::in_item_t in_item,
    output logic              item_valid,
    output lrs_pkg::in_item_t item,
    input  logic              item_take
);
    import lrs_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // The slot refills in the same cycle that the core consumes it.
    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: rtl/lrs_core.sv
module lrs_core #(
    parameter int TIME_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lrs_pkg::cfg_regs_t regs,
    input  logic               item_valid,
    input  lrs_pkg::in_item_t  item,
    output logic               item_take,
    output logic               out_valid,
    input  logic               out_ready,
    output lrs_pkg::out_item_t out_item
);
    import lrs_pkg::*;

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    link_fsm_t            state_reg, state_next;
    logic                 creds_reg, creds_next;
    logic                 portal_reg, portal_next;
    logic [CFG_W-1:0]     backoff_reg, backoff_next;
    logic [TIME_BITS-1:0] retry_reg, retry_next;
    logic [TIME_BITS-1:0] attempt_reg, attempt_next;
    logic [TIME_BITS-1:0] up_time_reg, up_time_next;
    logic [TIME_BITS-1:0] probe_time_reg, probe_time_next;

    logic                 out_valid_reg;
    out_item_t            out_item_reg, out_item_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] since_probe, since_attempt, since_up;
    logic                 probe_due, attempt_expired, outage_long;
    logic                 do_try, do_portal;
    logic [CFG_W:0]       twice;

    assign item_take = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign now_t         = TIME_BITS'(item.now_ms);
    assign since_probe   = now_t - probe_time_reg;
    assign since_attempt = now_t - attempt_reg;
    assign since_up      = now_t - up_time_reg;

    assign probe_due       = CMP_W'(since_probe) >= CMP_W'(regs.probe_interval_ms);
    assign attempt_expired = CMP_W'(since_attempt) > CMP_W'(regs.connect_timeout_ms);
    assign outage_long     = CMP_W'(since_up) >= CMP_W'(regs.portal_fallback_ms);

    always_comb
    begin
        state_next      = state_reg;
        creds_next      = creds_reg;
        portal_next     = portal_reg;
        backoff_next    = backoff_reg;
        retry_next      = retry_reg;
        attempt_next    = attempt_reg;
        up_time_next    = up_time_reg;
        probe_time_next = probe_time_reg;
        out_item_next   = '0;
        do_try          = 1'b0;
        do_portal       = 1'b0;
        twice           = '0;

        case (item.func)
            FUNC_TICK:
            begin
                if (item.link_up)
                begin
                    if (state_reg != LS_UP)
                    begin
                        out_item_next.ev_connected = 1'b1;
                        up_time_next               = now_t;
                        state_next                 = LS_UP;
                        backoff_next               = regs.backoff_min_ms;
                        retry_next                 = now_t;
                        attempt_next               = '0;
                        if (portal_reg)
                        begin
                            portal_next               = 1'b0;
                            out_item_next.portal_stop = 1'b1;
                        end
                    end
                    if (probe_due)
                    begin
                        probe_time_next          = now_t;
                        out_item_next.probe_used = 1'b1;
                        if (!item.probe_ok)
                        begin
                            out_item_next.ev_lost          = 1'b1;
                            out_item_next.issue_disconnect = 1'b1;
                            state_next                     = LS_DOWN;
                            retry_next                     = now_t;
                        end
                    end
                end
                else
                begin
                    if (state_next == LS_UP)
                    begin
                        out_item_next.ev_lost = 1'b1;
                        state_next            = LS_DOWN;
                        retry_next            = now_t;
                    end
                    if (state_next == LS_CONNECTING && attempt_expired)
                    begin
                        out_item_next.ev_timeout       = 1'b1;
                        out_item_next.issue_disconnect = 1'b1;
                        state_next                     = LS_DOWN;
                        retry_next                     = now_t + TIME_BITS'(backoff_reg);
                    end
                    // Retry time is compared as a plain magnitude, not as a wrapped gap.
                    do_try    = (state_next == LS_DOWN) && (now_t >= retry_next);
                    do_portal = !creds_reg || outage_long;
                end
            end
            FUNC_START:
            begin
                creds_next      = item.creds_present;
                up_time_next    = now_t;
                state_next      = LS_DOWN;
                backoff_next    = regs.backoff_min_ms;
                retry_next      = '0;
                probe_time_next = '0;
                do_try          = 1'b1;
                do_portal       = !item.creds_present;
            end
            FUNC_CREDS_SAVED:
            begin
                creds_next = 1'b1;
                do_try     = 1'b1;
            end
            FUNC_CREDS_CLEARED:
            begin
                creds_next                     = 1'b0;
                out_item_next.issue_disconnect = 1'b1;
                state_next                     = LS_DOWN;
                attempt_next                   = '0;
                backoff_next                   = regs.backoff_min_ms;
                retry_next                     = now_t + TIME_BITS'(regs.backoff_min_ms);
                do_portal                      = 1'b1;
            end
            default:
            begin
                out_item_next = '0;
            end
        endcase

        if (do_try && creds_next)
        begin
            out_item_next.issue_connect = 1'b1;
            state_next                  = LS_CONNECTING;
            attempt_next                = now_t;
            retry_next                  = now_t + TIME_BITS'(backoff_next);
            // Doubling is done one bit wider so it cannot wrap before the limit check.
            twice                       = {backoff_next, 1'b0};
            backoff_next = (twice < {1'b0, regs.backoff_max_ms}) ? twice[CFG_W-1:0]
                                                                 : regs.backoff_max_ms;
        end

        if (do_portal && !portal_reg)
        begin
            portal_next                = 1'b1;
            out_item_next.portal_start = 1'b1;
        end

        case (state_next)
            LS_DOWN:       out_item_next.link_state = LINK_DOWN;
            LS_CONNECTING: out_item_next.link_state = LINK_CONNECTING;
            LS_UP:         out_item_next.link_state = LINK_UP;
            default:       out_item_next.link_state = LINK_DOWN;
        endcase
        out_item_next.portal_active = portal_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= LS_DOWN;
            creds_reg      <= 1'b0;
            portal_reg     <= 1'b0;
            backoff_reg    <= BACKOFF_MIN_RST;
            retry_reg      <= '0;
            attempt_reg    <= '0;
            up_time_reg    <= '0;
            probe_time_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                state_reg      <= state_next;
                creds_reg      <= creds_next;
                portal_reg     <= portal_next;
                backoff_reg    <= backoff_next;
                retry_reg      <= retry_next;
                attempt_reg    <= attempt_next;
                up_time_reg    <= up_time_next;
                probe_time_reg <= probe_time_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

// File: rtl/link_reconnect_supervisor_top.sv
// Channel   Direction  Handshake               Beat contents
// in        input      in_valid / in_ready     in_item (event, time, link status)
// out       output     out_valid / out_ready   out_item (state, commands, flags)
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An event passes from input beat to result beat through the input register, then
// the supervisor logic into the result register. One event is accepted per cycle
// unless the result stalls; the state update between events is the loop.
// Reset clears the link state, credentials, portal flag and timers; the
// configuration registers return to their defaults. A stalled result holds the
// next event in the input register, and then in_ready falls.
module link_reconnect_supervisor_top #(
    parameter int TIME_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  lrs_pkg::in_item_t         in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output lrs_pkg::out_item_t        out_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [lrs_pkg::CFG_W-1:0] cfg_data
);
    import lrs_pkg::*;

    cfg_regs_t regs;
    logic      item_valid;
    in_item_t  item;
    logic      item_take;

    lrs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    lrs_in_buf u_in_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    lrs_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (regs),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule
